FILE: src/urmc_pkg.sv
// Package with shared types, constants and codes for the ultrasonic range motion classifier.
`default_nettype none
package urmc_pkg;

  localparam int TimeW  = 40;
  localparam int DistW  = 17;
  localparam int SpeedW = 14;
  localparam int CountW = 16;
  localparam int CfgW   = 24;
  localparam int CfgIdxW = 3;

  // Opcodes of an input item.
  localparam logic [1:0] OP_RISE = 2'd0;
  localparam logic [1:0] OP_FALL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_MIN_ECHO  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_ECHO  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_JUMP      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TRIG_INT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPEED_INT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HOLD      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ANGRY     = 3'd6;

  // Motion levels.
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_SLOW = 2'd1;
  localparam logic [1:0] LVL_FAST = 2'd2;
  localparam logic [1:0] LVL_BACK = 2'd3;

  localparam logic [DistW-1:0] DistMax   = 17'd131071;
  localparam logic [DistW-1:0] NearZero  = 17'd25;
  localparam logic [DistW-1:0] BigChange = 17'd5120;

  // Divider: magnitude of num is below 5121*1e6 < 2^33; den is at least 256, so the
  // quotient fits in NumW bits with room to spare.
  localparam int NumW = 33;
  localparam int DenW = 48;
  localparam int DivSteps = NumW;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // latch input item fields
    logic fall_scale;  // register the scaled echo width
    logic fall_raw;    // register the raw distance
    logic do_fall;     // perform falling edge processing
    logic do_rise;     // record rising edge
    logic do_trig;     // tick: trigger decision and speed due check
    logic eval_first;  // first evaluation record
    logic eval_setup;  // take delta and denominator, start divide
    logic div_step;    // one restoring divide step
    logic eval_finish; // classify and update level
    logic out_load;    // load output register
  } urmc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_rise;
    logic is_fall;
    logic is_tick;
    logic speed_due;
    logic first_eval;
    logic big_change;
    logic div_done;
  } urmc_stat_t;

endpackage
`default_nettype wire

FILE: src/urmc_ctrl.sv
// Controller state machine sequencing one item through the datapath.
`default_nettype none
module urmc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire urmc_pkg::urmc_stat_t stat,
  output urmc_pkg::urmc_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RAW, S_FALL, S_EVAL, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  // Accept a new item only while idle and the output register is free.
  assign in_stall = !(state == S_IDLE) || (out_valid && out_stall);

  // Next state and commands.
  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_item = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_rise) begin
          cmd.do_rise = 1'b1;
          state_next = S_OUT;
        end else if (stat.is_fall) begin
          cmd.fall_scale = 1'b1;
          state_next = S_RAW;
        end else if (stat.is_tick) begin
          cmd.do_trig = 1'b1;
          state_next = stat.speed_due ? S_EVAL : S_OUT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_RAW: begin
        cmd.fall_raw = 1'b1;
        state_next = S_FALL;
      end
      S_FALL: begin
        cmd.do_fall = 1'b1;
        state_next = S_OUT;
      end
      S_EVAL: begin
        if (stat.first_eval) begin
          cmd.eval_first = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.eval_setup = 1'b1;
          state_next = stat.big_change ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.eval_finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!(out_valid && out_stall)) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/urmc_dp.sv
// Datapath: configuration, ranging state, speed divider and classification.
`default_nettype none
module urmc_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [urmc_pkg::CfgIdxW-1:0]          cfg_index,
  input  wire logic [urmc_pkg::CfgW-1:0]             cfg_data,
  input  wire logic [1:0]                            opcode,
  input  wire logic [urmc_pkg::CountW-1:0]           echo_count,
  input  wire logic [urmc_pkg::TimeW-1:0]            now_us,
  input  wire urmc_pkg::urmc_cmd_t                   cmd,
  output urmc_pkg::urmc_stat_t                       stat,
  output logic                                       trigger,
  output logic [urmc_pkg::DistW-1:0]                 distance,
  output logic                                       new_distance,
  output logic [1:0]                                 motion_level,
  output logic signed [urmc_pkg::SpeedW-1:0]         speed
);
  localparam int TW = urmc_pkg::TimeW;
  localparam int DW = urmc_pkg::DistW;
  localparam int NW = urmc_pkg::NumW;
  localparam int EW = urmc_pkg::DenW;

  // Configuration registers.
  logic [15:0] min_echo, max_echo;
  logic [DW-1:0] jump_limit;
  logic [23:0] trig_int, speed_int, hold_time;
  logic angry;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_echo <= 16'd300;
      max_echo <= 16'd50000;
      jump_limit <= 17'd10240;
      trig_int <= 24'd30000;
      speed_int <= 24'd100000;
      hold_time <= 24'd2500000;
      angry <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urmc_pkg::REG_MIN_ECHO:  min_echo <= cfg_data[15:0];
        urmc_pkg::REG_MAX_ECHO:  max_echo <= cfg_data[15:0];
        urmc_pkg::REG_JUMP:      jump_limit <= cfg_data[DW-1:0];
        urmc_pkg::REG_TRIG_INT:  trig_int <= cfg_data;
        urmc_pkg::REG_SPEED_INT: speed_int <= cfg_data;
        urmc_pkg::REG_HOLD:      hold_time <= cfg_data;
        urmc_pkg::REG_ANGRY:     angry <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Latched input item.
  logic [1:0] op_q;
  logic [15:0] cnt_q;
  logic [TW-1:0] now_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q <= opcode;
      cnt_q <= echo_count;
      now_q <= now_us;
    end
  end

  // Block state.
  logic measuring, first_eval, trig_q, fresh_q;
  logic [15:0] echo_start;
  logic [DW-1:0] filt, dist_ref;
  logic [TW-1:0] last_trig, last_spd, last_mot;
  logic [1:0] held;
  logic signed [urmc_pkg::SpeedW-1:0] last_speed;

  // Falling edge: width, raw distance, jump check and blend.
  // Raw distance rounds width * 21952 / 10000 half up, written as (w * 2744 + 625) / 1250.
  logic [15:0] width;
  logic [27:0] scaled, scaled_q;
  logic [55:0] raw_prod;
  logic [17:0] rq;
  logic [DW-1:0] raw_q, jump;
  logic [20:0] blend_sum;
  logic [42:0] blend_prod;
  logic [DW-1:0] blended;
  logic width_ok;

  assign width = cnt_q - echo_start;
  assign width_ok = !(width < min_echo) && !(width > max_echo);
  assign scaled = 28'(width) * 28'd2744 + 28'd625;
  // Division by 1250 as a multiply by ceil(2^38 / 1250), exact over the scaled range.
  assign raw_prod = 56'(scaled_q) * 56'd219902326;
  assign rq = raw_prod[55:38];
  assign jump = (raw_q > filt) ? raw_q - filt : filt - raw_q;
  assign blend_sum = 21'd3 * 21'(filt) + 21'd7 * 21'(raw_q) + 21'd5;
  // Division by 10 as a multiply by ceil(2^25 / 10), exact over the blend range.
  assign blend_prod = 43'(blend_sum) * 43'd3355444;
  assign blended = blend_prod[25 +: DW];

  // Scaled width and saturated raw distance, one registered step each.
  always_ff @(posedge clk) begin
    if (cmd.fall_scale) begin
      scaled_q <= scaled;
    end
    if (cmd.fall_raw) begin
      raw_q <= (rq > 18'(urmc_pkg::DistMax)) ? urmc_pkg::DistMax : rq[DW-1:0];
    end
  end

  // Tick checks.
  logic [TW-1:0] dt_trig, dt_spd, dt_mot;
  assign dt_trig = now_q - last_trig;
  assign dt_spd = now_q - last_spd;
  assign dt_mot = now_q - last_mot;

  // Speed evaluation: signed delta, sign-magnitude numerator, denominator.
  logic signed [DW:0] delta;
  logic [DW-1:0] mag;
  logic big;
  assign delta = $signed({1'b0, filt}) - $signed({1'b0, dist_ref});
  assign mag = delta[DW] ? DW'(-delta) : delta[DW-1:0];
  assign big = mag > urmc_pkg::BigChange;

  // Divider registers: restoring division of |num| by den, one bit per step.
  logic neg;
  logic [NW-1:0] num_mag;
  logic [EW-1:0] den;
  logic [NW-1:0] quo;
  logic [EW:0] rem;
  logic [5:0] step;
  logic [EW:0] rem_shift;
  logic [EW:0] rem_sub;

  assign rem_shift = {rem[EW-1:0], num_mag[NW-1]};
  assign rem_sub = rem_shift - {1'b0, den};

  // Final classification on exact quotient and remainder.
  // |num| compared with k*den via quotient: |num| < k*den iff q < k.
  logic zero_band;
  logic [1:0] level;
  logic signed [urmc_pkg::SpeedW-1:0] sat_q;
  logic exact;
  always_comb begin
    exact = (rem == '0);
    zero_band = quo < NW'(8);
    level = urmc_pkg::LVL_NONE;
    if (quo > NW'(8191) && !neg) begin
      sat_q = 14'sd8191;
    end else if (quo > NW'(8191)) begin
      sat_q = -14'sd8192;
    end else if (neg) begin
      sat_q = -$signed(quo[13:0]);
    end else begin
      sat_q = $signed(quo[13:0]);
    end
    if (neg) begin
      // -15 < v < -5 means 5 < |v| < 15.
      if ((quo > NW'(5) || (quo == NW'(5) && !exact)) && quo < NW'(15)) begin
        level = angry ? urmc_pkg::LVL_NONE : urmc_pkg::LVL_SLOW;
      end else if (!(quo < NW'(15))) begin
        level = urmc_pkg::LVL_FAST;
      end
    end else if (quo > NW'(4) || (quo == NW'(4) && !exact)) begin
      level = urmc_pkg::LVL_BACK;
    end
  end

  // State updates by command.
  always_ff @(posedge clk) begin
    if (rst) begin
      measuring <= 1'b0;
      echo_start <= '0;
      filt <= '0;
      last_trig <= '0;
      last_spd <= '0;
      dist_ref <= '0;
      last_mot <= '0;
      first_eval <= 1'b1;
      held <= urmc_pkg::LVL_NONE;
      last_speed <= '0;
      trig_q <= 1'b0;
      fresh_q <= 1'b0;
      step <= '0;
    end else begin
      if (cmd.load_item) begin
        trig_q <= 1'b0;
        fresh_q <= 1'b0;
      end
      if (cmd.do_rise) begin
        echo_start <= cnt_q;
        measuring <= 1'b1;
      end
      if (cmd.do_fall && measuring) begin
        measuring <= 1'b0;
        if (width_ok) begin
          if (filt > urmc_pkg::NearZero) begin
            if (!(jump > jump_limit)) begin
              filt <= blended;
              fresh_q <= 1'b1;
            end
          end else begin
            filt <= raw_q;
            fresh_q <= 1'b1;
          end
        end
      end
      if (cmd.do_trig && dt_trig > TW'(trig_int) && !measuring) begin
        trig_q <= 1'b1;
        measuring <= 1'b1;
        last_trig <= now_q;
      end
      if (cmd.eval_first) begin
        dist_ref <= filt;
        last_spd <= now_q;
        first_eval <= 1'b0;
      end
      if (cmd.eval_setup) begin
        dist_ref <= filt;
        last_spd <= now_q;
        neg <= delta[DW];
        num_mag <= NW'(mag) * NW'(1000000);
        den <= (dt_spd == '0) ? EW'(256) : {dt_spd, 8'd0};
        quo <= '0;
        rem <= '0;
        step <= '0;
      end
      if (cmd.div_step) begin
        num_mag <= {num_mag[NW-2:0], 1'b0};
        if (!rem_sub[EW]) begin
          rem <= rem_sub;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[NW-2:0], 1'b0};
        end
        step <= step + 6'd1;
      end
      if (cmd.eval_finish) begin
        if (zero_band) begin
          last_speed <= '0;
        end else begin
          last_speed <= sat_q;
        end
        if (!zero_band && level != urmc_pkg::LVL_NONE) begin
          held <= level;
          last_mot <= now_q;
        end else if (dt_mot > TW'(hold_time)) begin
          held <= urmc_pkg::LVL_NONE;
        end
      end
    end
  end

  // Status to the controller.
  always_comb begin
    stat.is_rise = (op_q == urmc_pkg::OP_RISE);
    stat.is_fall = (op_q == urmc_pkg::OP_FALL);
    stat.is_tick = (op_q == urmc_pkg::OP_TICK);
    stat.speed_due = dt_spd > TW'(speed_int);
    stat.first_eval = first_eval;
    stat.big_change = big;
    stat.div_done = (step == 6'(urmc_pkg::DivSteps - 1));
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      trigger <= trig_q;
      distance <= filt;
      new_distance <= fresh_q;
      motion_level <= held;
      speed <= last_speed;
    end
  end

endmodule
`default_nettype wire

FILE: src/ultrasonic_range_motion_classifier.sv
// Top level of the ultrasonic range motion classifier.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall  | opcode, echo_count, now_us
//  out     | output    | out_valid/out_stall| trigger, distance, new_distance, motion_level, speed
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Rising edges, plain ticks and unused opcodes go through execute and output; falling edges
// add the registered scaled width and raw distance steps, a tick with a first or skipped
// speed evaluation adds evaluate, and a divided one the 33-step restoring divider and finish.
// One item is in work at a time; the next is taken once the result sits in the output register.
// Synchronous reset sets control, config and ranging state, not item, divider or output data.
// A stalled output holds its item, and input is stalled until that register frees.
`default_nettype none
module ultrasonic_range_motion_classifier (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [urmc_pkg::CfgIdxW-1:0]          cfg_index,
  input  wire logic [urmc_pkg::CfgW-1:0]             cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            opcode,
  input  wire logic [urmc_pkg::CountW-1:0]           echo_count,
  input  wire logic [urmc_pkg::TimeW-1:0]            now_us,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       trigger,
  output logic [urmc_pkg::DistW-1:0]                 distance,
  output logic                                       new_distance,
  output logic [1:0]                                 motion_level,
  output logic signed [urmc_pkg::SpeedW-1:0]         speed
);

  urmc_pkg::urmc_cmd_t  cmd;
  urmc_pkg::urmc_stat_t stat;

  urmc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  urmc_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .opcode, .echo_count, .now_us,
    .cmd, .stat, .trigger, .distance, .new_distance, .motion_level, .speed
  );

endmodule
`default_nettype wire

FILE: test/urmc_checker.sv
// Checker that predicts each range and motion result and compares it with the block's output.
`timescale 1ns / 100ps
module urmc_checker
  import urmc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [CountW-1:0]  echo_count,
  input  wire logic [TimeW-1:0]   now_us,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               trigger,
  input  wire logic [DistW-1:0]   distance,
  input  wire logic               new_distance,
  input  wire logic [1:0]         motion_level,
  input  wire logic signed [SpeedW-1:0] speed,
  output int                      mismatch_count,
  output int                      results_pending
);

  typedef struct {
    logic                     trig;
    logic [DistW-1:0]         dist_out;
    logic                     fresh;
    logic [1:0]               lvl;
    logic signed [SpeedW-1:0] spd;
  } range_result_t;

  range_result_t awaited_results[$];

  // Configuration copy.
  logic [15:0] min_width, max_width;
  logic [16:0] max_jump;
  logic [23:0] trig_gap, speed_gap, hold_span;
  logic        angry;

  // Predictor state.
  logic              echo_open;
  logic [15:0]       echo_base;
  logic [DistW-1:0]  smooth_dist;
  logic [TimeW-1:0]  trig_stamp, speed_stamp, motion_stamp;
  logic [DistW-1:0]  ref_dist;
  logic              first_pass;
  logic [1:0]        level_held;
  longint            speed_cms;

  task automatic reset_model();
    min_width = 16'd300; max_width = 16'd50000; max_jump = 17'd10240;
    trig_gap = 24'd30000; speed_gap = 24'd100000; hold_span = 24'd2500000;
    angry = 1'b0;
    echo_open = 1'b0; echo_base = '0; smooth_dist = '0;
    trig_stamp = '0; speed_stamp = '0; motion_stamp = '0; ref_dist = '0;
    first_pass = 1'b1; level_held = LVL_NONE; speed_cms = 0;
  endtask

  // Speed evaluation: delta over elapsed time, dead band, then classification.
  task automatic evaluate_speed(input logic [TimeW-1:0] now);
    logic [TimeW-1:0] dt;
    longint den, delta, num, q;
    logic [1:0] lvl;
    lvl = LVL_NONE;
    if (first_pass) begin
      ref_dist = smooth_dist;
      speed_stamp = now;
      first_pass = 1'b0;
      return;
    end
    dt = now - speed_stamp;
    den = longint'(dt) * 256;
    if (den == 0) den = 256;
    delta = longint'(smooth_dist) - longint'(ref_dist);
    speed_stamp = now;
    ref_dist = smooth_dist;
    if (delta > 5120 || delta < -5120) return;
    num = delta * 1000000;
    if (num < 8 * den && num > -8 * den) begin
      speed_cms = 0;
    end else begin
      q = num / den;
      if (q > 8191) q = 8191;
      if (q < -8192) q = -8192;
      speed_cms = q;
      if (num < -5 * den && num > -15 * den) lvl = angry ? LVL_NONE : LVL_SLOW;
      else if (num <= -15 * den) lvl = LVL_FAST;
      else if (num > 4 * den) lvl = LVL_BACK;
    end
    dt = now - motion_stamp;
    if (lvl != LVL_NONE) begin
      level_held = lvl;
      motion_stamp = now;
    end else if (dt > hold_span) begin
      level_held = LVL_NONE;
    end
  endtask

  // Work out the result of one accepted item.
  task automatic predict_range(input logic [1:0] op, input logic [15:0] cnt,
                               input logic [TimeW-1:0] now, output range_result_t res);
    logic [15:0] width;
    longint raw, jump;
    logic [TimeW-1:0] dt;
    res.trig = 1'b0;
    res.fresh = 1'b0;
    case (op)
      OP_RISE: begin
        echo_base = cnt;
        echo_open = 1'b1;
      end
      OP_FALL: begin
        if (echo_open) begin
          echo_open = 1'b0;
          width = cnt - echo_base;
          if (width >= min_width && width <= max_width) begin
            raw = (longint'(width) * 21952 + 5000) / 10000;
            if (raw > 131071) raw = 131071;
            if (smooth_dist > NearZero) begin
              jump = raw - longint'(smooth_dist);
              if (jump < 0) jump = -jump;
              if (jump <= longint'(max_jump)) begin
                smooth_dist = DistW'((3 * longint'(smooth_dist) + 7 * raw + 5) / 10);
                res.fresh = 1'b1;
              end
            end else begin
              smooth_dist = DistW'(raw);
              res.fresh = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        dt = now - trig_stamp;
        if (dt > trig_gap && !echo_open) begin
          res.trig = 1'b1;
          echo_open = 1'b1;
          trig_stamp = now;
        end
        dt = now - speed_stamp;
        if (dt > speed_gap) evaluate_speed(now);
      end
      default: ;
    endcase
    res.dist_out = smooth_dist;
    res.lvl = level_held;
    res.spd = speed_cms[SpeedW-1:0];
  endtask

  // Watch all three ports; results are compared before a new item is predicted.
  always @(posedge clk) begin
    range_result_t exp_res, got;
    if (rst) begin
      reset_model();
      awaited_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_ECHO:  min_width = cfg_data[15:0];
          REG_MAX_ECHO:  max_width = cfg_data[15:0];
          REG_JUMP:      max_jump = cfg_data[16:0];
          REG_TRIG_INT:  trig_gap = cfg_data;
          REG_SPEED_INT: speed_gap = cfg_data;
          REG_HOLD:      hold_span = cfg_data;
          REG_ANGRY:     angry = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.trig = trigger; got.dist_out = distance; got.fresh = new_distance;
        got.lvl = motion_level; got.spd = speed;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result item with nothing expected", $realtime);
        end else begin
          exp_res = awaited_results.pop_front();
          if (got.trig !== exp_res.trig || got.dist_out !== exp_res.dist_out ||
              got.fresh !== exp_res.fresh || got.lvl !== exp_res.lvl ||
              got.spd !== exp_res.spd) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: expected trig %0b dist %0d new %0b lvl %0d speed %0d,",
                        " got %0b %0d %0b %0d %0d"},
                       $realtime, exp_res.trig, exp_res.dist_out, exp_res.fresh,
                       exp_res.lvl, exp_res.spd, got.trig, got.dist_out, got.fresh,
                       got.lvl, got.spd);
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_range(opcode, echo_count, now_us, exp_res);
        awaited_results.push_back(exp_res);
      end
    end
    results_pending = awaited_results.size();
  end

endmodule

FILE: test/ultrasonic_range_motion_classifier_tb.sv
// Testbench top: stimulus, flow control, watchdog and verdict for the range motion classifier.
`timescale 1ns / 100ps
module ultrasonic_range_motion_classifier_tb;
  import urmc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = OP_RISE;
  logic [CountW-1:0] echo_count = '0;
  logic [TimeW-1:0] now_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic trigger, new_distance;
  logic [DistW-1:0] distance;
  logic [1:0] motion_level;
  logic signed [SpeedW-1:0] speed;
  int mismatch_count, results_pending;

  int burst_left = 0;
  int quiet_cycles = 0;
  logic long_hold_req = 1'b0;
  logic [TimeW-1:0] clock_us = '0;
  int echo_width = 3000;

  always #1 clk = ~clk;

  ultrasonic_range_motion_classifier u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .echo_count(echo_count),
    .now_us(now_us), .out_valid(out_valid), .out_stall(out_stall), .trigger(trigger),
    .distance(distance), .new_distance(new_distance), .motion_level(motion_level),
    .speed(speed)
  );

  urmc_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .echo_count(echo_count),
    .now_us(now_us), .out_valid(out_valid), .out_stall(out_stall), .trigger(trigger),
    .distance(distance), .new_distance(new_distance), .motion_level(motion_level),
    .speed(speed), .mismatch_count(mismatch_count), .results_pending(results_pending)
  );

  // Watchdog: cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: a randomly chosen stall mode (free, random or mostly stalled), plus one long hold-off.
  initial begin
    int mode, phase_cnt, hold_cnt;
    mode = 0; phase_cnt = 0; hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req && hold_cnt == 0) hold_cnt = 400;
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) long_hold_req = 1'b0;
        out_stall = 1'b1;
      end else begin
        phase_cnt++;
        if (phase_cnt % 64 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = 1'($urandom_range(0, 1));
          default: out_stall = (phase_cnt % 4 != 0);
        endcase
      end
    end
  end

  // Offer one item, with bursts and gaps, and wait until it is taken.
  task automatic send_item(input logic [1:0] op, input logic [15:0] cnt,
                           input logic [TimeW-1:0] now);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid = 1'b1;
    opcode = op;
    echo_count = cnt;
    now_us = now;
    do @(posedge clk); while (in_stall);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
  endtask

  // Drain all results, then let the divider settle before touching registers.
  task automatic wait_idle();
    in_valid = 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] mn, input logic [15:0] mx, input logic [16:0] jl,
                            input logic [23:0] tg, input logic [23:0] sg, input logic [23:0] hd,
                            input logic ag);
    wait_idle();
    write_reg(REG_MIN_ECHO, 24'(mn));
    write_reg(REG_MAX_ECHO, 24'(mx));
    write_reg(REG_JUMP, 24'(jl));
    write_reg(REG_TRIG_INT, tg);
    write_reg(REG_SPEED_INT, sg);
    write_reg(REG_HOLD, hd);
    write_reg(REG_ANGRY, 24'(ag));
    cfg_we = 1'b0;
  endtask

  // Mostly tick/rise/fall/tick measurement cycles on a drifting echo width, plus noise.
  task automatic run_phase(input int n_items);
    int sent;
    logic [15:0] base;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 19) == 0)
          echo_width += $urandom_range(0, 16000) - 8000;
        else
          echo_width += $urandom_range(0, 120) - 60;
        if (echo_width < 200) echo_width = 200;
        if (echo_width > 45000) echo_width = 45000;
        base = 16'($urandom);
        clock_us += $urandom_range(1, 15000);
        send_item(OP_TICK, 16'($urandom), clock_us);
        send_item(OP_RISE, base, 40'($urandom));
        send_item(OP_FALL, base + 16'(echo_width), 40'($urandom));
        clock_us += $urandom_range(1, 15000);
        send_item(OP_TICK, 16'($urandom), clock_us);
        sent += 4;
      end else begin
        if ($urandom_range(0, 1) == 0)
          send_item(2'($urandom_range(0, 3)), 16'($urandom), 40'({$urandom, $urandom}));
        else
          send_item(2'($urandom_range(0, 3)), 16'($urandom), clock_us);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed items at the reset register values.
    send_item(2'd3, 16'hFFFF, 40'hFFFFFFFFFF);
    send_item(OP_FALL, 16'd1234, 40'd0);
    send_item(OP_TICK, 16'd0, 40'd0);
    send_item(OP_TICK, 16'd0, 40'd40000);
    send_item(OP_RISE, 16'd65000, 40'd0);
    send_item(OP_FALL, 16'd65000 + 16'd3000, 40'd0);
    send_item(OP_RISE, 16'd0, 40'd0);
    send_item(OP_FALL, 16'd299, 40'd0);
    send_item(OP_RISE, 16'd0, 40'd0);
    send_item(OP_FALL, 16'd300, 40'd0);
    send_item(OP_RISE, 16'd0, 40'd0);
    send_item(OP_FALL, 16'd3000, 40'd0);
    send_item(OP_RISE, 16'd100, 40'd0);
    send_item(OP_FALL, 16'd50100, 40'd0);
    send_item(OP_RISE, 16'd0, 40'd0);
    send_item(OP_FALL, 16'd50001, 40'd0);
    send_item(OP_RISE, 16'd0, 40'd0);
    send_item(OP_FALL, 16'd65535, 40'd0);
    send_item(OP_TICK, 16'd0, 40'd150000);
    send_item(OP_RISE, 16'd0, 40'd0);
    send_item(OP_FALL, 16'd3100, 40'd0);
    send_item(OP_TICK, 16'd0, 40'd300000);
    send_item(OP_TICK, 16'd0, 40'hFFFFFFFFFF);
    send_item(OP_TICK, 16'd0, 40'd1000);
    send_item(OP_RISE, 16'd0, 40'd0);
    send_item(OP_FALL, 16'd6000, 40'd0);
    send_item(OP_TICK, 16'd0, 40'd200000);
    clock_us = 40'd200000;

    set_config(16'd300, 16'd50000, 17'd10240, 24'd5000, 24'd20000, 24'd60000, 1'b0);
    run_phase(250);
    long_hold_req = 1'b1;
    run_phase(250);

    // Widest acceptance, zero intervals, and a start just before time wraps.
    set_config(16'd0, 16'hFFFF, 17'h1FFFF, 24'd0, 24'd0, 24'd0, 1'b1);
    clock_us = 40'hFFFFF80000;
    run_phase(400);

    // Every width but 65535 rejected, longest intervals.
    set_config(16'hFFFF, 16'hFFFF, 17'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    run_phase(100);

    set_config(16'd200, 16'd40000, 17'd3000, 24'd20000, 24'd50000, 24'd200000, 1'b1);
    run_phase(500);

    wait_idle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
